// ===== src/prewitt_edge_nms_threshold_defines.svh =====
// Assertion macros for the top-level file, which checks its own logic.
`ifndef PREWITT_EDGE_NMS_THRESHOLD_DEFINES_SVH
`define PREWITT_EDGE_NMS_THRESHOLD_DEFINES_SVH
`ifndef ASSERT_OFF
`define PENT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PENT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PENT_ASSERT_IMP(lbl, ante, cons, msg)
`define PENT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/pent_pkg.sv =====
`timescale 1ns / 1ps
package pent_pkg;

    localparam int MAX_WIDTH_DEF        = 1024;
    localparam int MAX_HEIGHT_DEF       = 1024;
    localparam int THRESHOLD_FACTOR_DEF = 4;
    localparam int MASK_RADIUS_DEF      = 2;

    localparam int DIM_W     = 11;
    localparam int PIX_W     = 8;
    localparam int EDGE_W    = 8;
    localparam int EN_W      = 20;
    localparam int G_W       = 11;
    localparam int CFG_IDX_W = 2;
    localparam int MIN_DIM   = 3;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd480;

    localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int GRAD_TAPS = 6;
    localparam int GRAD_HALF = 3;
    localparam int GK_W      = 3;
    localparam int NB_TAPS   = 5;
    localparam int RK_W      = 3;
    localparam int DRAIN_W   = 2;
    localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_VMODE  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } cmd_kind_t;

    typedef enum logic [RK_W-1:0] {
        NB_C = 3'd0,
        NB_L = 3'd1,
        NB_R = 3'd2,
        NB_U = 3'd3,
        NB_D = 3'd4
    } nb_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_ISSUE,
        ST_C_DRAIN,
        ST_C_SQ,
        ST_C_WR,
        ST_R_ISSUE,
        ST_R_WAIT,
        ST_R_MUL,
        ST_R_DONE
    } back_state_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [PIX_W-1:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             vmode;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== src/pent_if.sv =====
`timescale 1ns / 1ps
interface pent_item_if import pent_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, kind, pixel, input ready);
    modport sink (input valid, kind, pixel, output ready);
endinterface

interface pent_res_if import pent_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [EDGE_W-1:0] edge_res;
    logic              last;
    logic              not_ready;
    modport source (output valid, edge_res, last, not_ready, input ready);
    modport sink (input valid, edge_res, last, not_ready, output ready);
endinterface

interface pent_cfg_if import pent_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/pent_front.sv =====
`timescale 1ns / 1ps
module pent_front import pent_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    pent_item_if.sink items,
    pent_cfg_if.sink  cfg,
    input  q_status_t q_stat,
    output logic      q_push,
    output cmd_t      q_cmd,
    output cfg_t      cfg_regs
);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             vmode_reg, vmode_next;

    assign items.ready = !q_stat.full;
    assign cfg.ready   = 1'b1;
    assign q_push      = items.valid && !q_stat.full;

    always_comb
    begin
        q_cmd.kind  = (items.kind == 1'b1) ? CMD_READ : CMD_LOAD;
        q_cmd.pixel = items.pixel;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        vmode_next  = vmode_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_WIDTH:  width_next  = cfg.data;
                REG_HEIGHT: height_next = cfg.data;
                REG_VMODE:  vmode_next  = cfg.data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            vmode_reg  <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            vmode_reg  <= vmode_next;
        end
    end

    always_comb
    begin
        cfg_regs.width  = width_reg;
        cfg_regs.height = height_reg;
        cfg_regs.vmode  = vmode_reg;
    end

endmodule

// ===== src/pent_fifo.sv =====
`timescale 1ns / 1ps
module pent_fifo import pent_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head_cmd,
    output q_status_t stat
);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == QC_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QC_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/pent_back.sv =====
`timescale 1ns / 1ps
module pent_back import pent_pkg::*; #(
    parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = MAX_HEIGHT_DEF,
    parameter int THRESHOLD_FACTOR = THRESHOLD_FACTOR_DEF,
    parameter int MASK_RADIUS      = MASK_RADIUS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg_regs,
    input  q_status_t   q_stat,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    pent_res_if.source  results
);

    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int DM_W  = (WD_W > HT_W) ? WD_W : HT_W;
    localparam int CO_W  = DM_W + 2;
    localparam int MA_W  = 2 * DM_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int ETW   = EN_W + AW;
    localparam int PRW   = EN_W + TW;
    localparam int THW   = ETW + $clog2(THRESHOLD_FACTOR + 1);
    localparam int CMW   = (PRW > THW) ? PRW : THW;
    localparam logic signed [CO_W-1:0] RAD = CO_W'(MASK_RADIUS);

    function automatic logic [DM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned lim);
        logic [DM_W-1:0] r;
        if (v < DIM_W'(MIN_DIM))
            r = DM_W'(MIN_DIM);
        else if (32'(v) > lim)
            r = DM_W'(lim);
        else
            r = DM_W'(v);
        return r;
    endfunction

    function automatic logic signed [CO_W-1:0] mirror(input logic signed [CO_W-1:0] i,
                                                      input logic [DM_W-1:0] n);
        logic signed [CO_W-1:0] ns;
        logic signed [CO_W-1:0] r;
        ns = $signed({2'b00, n});
        if (i < 0)
            r = CO_W'(1);
        else if (i >= ns)
            r = ns - CO_W'(2);
        else
            r = i;
        return r;
    endfunction

    logic [PIX_W-1:0] fmem [DEPTH];
    logic [EN_W-1:0]  emem [DEPTH];

    back_state_t state_reg, state_next;

    logic [DM_W-1:0] cur_w_reg, cur_w_next;
    logic [DM_W-1:0] cur_h_reg, cur_h_next;
    logic            cur_v_reg, cur_v_next;
    logic [TW-1:0]   total_reg, total_next;
    logic [TW-1:0]   load_pos_reg, load_pos_next;
    logic            frame_ready_reg, frame_ready_next;

    logic [DM_W-1:0]        cx_reg, cx_next;
    logic [DM_W-1:0]        cy_reg, cy_next;
    logic [AW-1:0]          cpos_reg, cpos_next;
    logic [GK_W-1:0]        gk_reg, gk_next;
    logic                   mask_ph_reg, mask_ph_next;
    logic signed [CO_W-1:0] mdx_reg, mdx_next;
    logic signed [CO_W-1:0] mdy_reg, mdy_next;
    logic [DRAIN_W-1:0]     drain_reg, drain_next;
    logic signed [G_W-1:0]  g_reg, g_next;
    logic                   black_reg, black_next;
    logic [EN_W-1:0]        sq_reg, sq_next;
    logic [ETW-1:0]         etot_reg, etot_next;

    logic            a_vld_reg, a_vld_next;
    logic [AW-1:0]   a_addr_reg, a_addr_next;
    logic            a_sign_reg, a_sign_next;
    logic            a_ring_reg, a_ring_next;
    logic            a_mask_reg, a_mask_next;
    logic            b_vld_reg, b_vld_next;
    logic            b_sign_reg, b_sign_next;
    logic            b_ring_reg, b_ring_next;
    logic            b_mask_reg, b_mask_next;
    logic [PIX_W-1:0] fdata_reg;

    logic [AW-1:0]   rpos_reg, rpos_next;
    logic [DM_W-1:0] rx_reg, rx_next;
    logic [DM_W-1:0] ry_reg, ry_next;
    logic [RK_W-1:0] rk_reg, rk_next;
    logic            cap_vld_reg, cap_vld_next;
    logic [RK_W-1:0] cap_idx_reg, cap_idx_next;
    logic [EN_W-1:0] nb_reg [NB_TAPS];
    logic [EN_W-1:0] nb_next [NB_TAPS];
    logic [PRW-1:0]  prod_reg, prod_next;
    logic [EN_W-1:0] edata_reg;

    logic              res_valid_reg, res_valid_next;
    logic [EDGE_W-1:0] res_edge_reg, res_edge_next;
    logic              res_last_reg, res_last_next;
    logic              res_nr_reg, res_nr_next;

    logic pop;
    logic load_end;
    logic interior;
    logic issue_done;
    logic c_last;
    logic rlast;

    logic            fwe;
    logic [AW-1:0]   faddr_w;
    logic            ewe;
    logic [AW-1:0]   eaddr_r;

    logic signed [CO_W-1:0] cxs, cys, wsz, hsz, gj, gs, yy, xx;
    logic                   lo;
    logic [GK_W-1:0]        goff;
    logic                   iss_vld;
    logic                   ring;
    logic [MA_W-1:0]        ma;

    logic [DM_W-1:0]           lw, lh;
    logic [MA_W-1:0]           ltot;
    logic [PIX_W-1:0]          wp;
    logic signed [2*G_W-1:0]   gsq;
    logic [CMW-1:0]            thr;
    logic                      over;
    logic                      row_max;
    logic                      col_max;

    assign pop = (state_reg == ST_IDLE) && !q_stat.empty
                 && ((q_cmd.kind == CMD_LOAD) || !res_valid_reg);
    assign load_end = (load_pos_reg != '0) && ((load_pos_reg + TW'(1)) >= total_reg);
    assign interior = (ry_reg != '0) && (rx_reg != '0)
                      && (ry_reg != cur_h_reg - DM_W'(1)) && (rx_reg != cur_w_reg - DM_W'(1));
    assign issue_done = mask_ph_reg ? ((mdx_reg == RAD) && (mdy_reg == RAD))
                                    : ((gk_reg == GK_W'(GRAD_TAPS - 1)) && !cur_v_reg);
    assign c_last = (cx_reg == cur_w_reg - DM_W'(1)) && (cy_reg == cur_h_reg - DM_W'(1));
    assign rlast  = (TW'(rpos_reg) == total_reg - TW'(1));

    // window coordinates of the current fetch
    always_comb
    begin
        cxs  = $signed({2'b00, cx_reg});
        cys  = $signed({2'b00, cy_reg});
        wsz  = $signed({2'b00, cur_w_reg});
        hsz  = $signed({2'b00, cur_h_reg});
        lo   = gk_reg < GK_W'(GRAD_HALF);
        goff = lo ? gk_reg : gk_reg - GK_W'(GRAD_HALF);
        gj   = CO_W'(goff);
        gj   = gj - CO_W'(1);
        gs   = lo ? {CO_W{1'b1}} : CO_W'(1);
        if (!mask_ph_reg)
        begin
            if (cur_v_reg)
            begin
                xx = mirror(cxs + gs, cur_w_reg);
                yy = mirror(cys + gj, cur_h_reg);
            end
            else
            begin
                yy = mirror(cys + gs, cur_h_reg);
                xx = mirror(cxs + gj, cur_w_reg);
            end
            iss_vld = 1'b1;
        end
        else
        begin
            yy      = cys + mdy_reg;
            xx      = cxs + mdx_reg;
            iss_vld = (yy >= 0) && (xx >= 0) && (yy < hsz) && (xx < wsz);
        end
        ring = cur_v_reg && ((xx == 0) || (yy == 0) || (xx == wsz - 1) || (yy == hsz - 1));
        ma   = MA_W'(yy[DM_W-1:0]) * MA_W'(cur_w_reg) + MA_W'(xx[DM_W-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (q_cmd.kind == CMD_LOAD)
                    begin
                        if (load_end)
                            state_next = ST_C_ISSUE;
                    end
                    else if (frame_ready_reg && interior)
                    begin
                        state_next = ST_R_ISSUE;
                    end
                end
            end
            ST_C_ISSUE: if (issue_done) state_next = ST_C_DRAIN;
            ST_C_DRAIN: if (drain_reg == DRAIN_LAST) state_next = ST_C_SQ;
            ST_C_SQ:    state_next = ST_C_WR;
            ST_C_WR:    state_next = c_last ? ST_IDLE : ST_C_ISSUE;
            ST_R_ISSUE: if (rk_reg == RK_W'(NB_TAPS - 1)) state_next = ST_R_WAIT;
            ST_R_WAIT:  state_next = ST_R_MUL;
            ST_R_MUL:   state_next = ST_R_DONE;
            ST_R_DONE:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cur_w_next       = cur_w_reg;
        cur_h_next       = cur_h_reg;
        cur_v_next       = cur_v_reg;
        total_next       = total_reg;
        load_pos_next    = load_pos_reg;
        frame_ready_next = frame_ready_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        cpos_next        = cpos_reg;
        gk_next          = gk_reg;
        mask_ph_next     = mask_ph_reg;
        mdx_next         = mdx_reg;
        mdy_next         = mdy_reg;
        drain_next       = drain_reg;
        g_next           = g_reg;
        black_next       = black_reg;
        sq_next          = sq_reg;
        etot_next        = etot_reg;
        a_vld_next       = 1'b0;
        a_addr_next      = ma[AW-1:0];
        a_sign_next      = lo;
        a_ring_next      = ring;
        a_mask_next      = mask_ph_reg;
        b_vld_next       = a_vld_reg;
        b_sign_next      = a_sign_reg;
        b_ring_next      = a_ring_reg;
        b_mask_next      = a_mask_reg;
        rpos_next        = rpos_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        rk_next          = rk_reg;
        cap_vld_next     = 1'b0;
        cap_idx_next     = rk_reg;
        nb_next          = nb_reg;
        prod_next        = prod_reg;
        res_valid_next   = res_valid_reg && !results.ready;
        res_edge_next    = res_edge_reg;
        res_last_next    = res_last_reg;
        res_nr_next      = res_nr_reg;
        fwe              = 1'b0;
        faddr_w          = load_pos_reg[AW-1:0];
        ewe              = 1'b0;
        eaddr_r          = rpos_reg;
        q_pop            = pop;

        lw      = clamp_dim(cfg_regs.width, MAX_WIDTH);
        lh      = clamp_dim(cfg_regs.height, MAX_HEIGHT);
        ltot    = MA_W'(lw) * MA_W'(lh);
        wp      = b_ring_reg ? '0 : fdata_reg;
        gsq     = g_reg * g_reg;
        thr     = CMW'(etot_reg) * CMW'(THRESHOLD_FACTOR);
        over    = CMW'(prod_reg) > thr;
        row_max = (nb_reg[NB_C] > nb_reg[NB_L]) && (nb_reg[NB_C] > nb_reg[NB_R]);
        col_max = (nb_reg[NB_C] > nb_reg[NB_U]) && (nb_reg[NB_C] > nb_reg[NB_D]);

        if (cap_vld_reg)
        begin
            nb_next[cap_idx_reg] = edata_reg;
        end

        // accumulate the fetched gradient taps, or flag a dark pixel in the mask window
        if (b_vld_reg)
        begin
            if (!b_mask_reg)
                g_next = b_sign_reg ? g_reg + G_W'(wp) : g_reg - G_W'(wp);
            else
                black_next = black_reg || b_ring_reg || (fdata_reg == '0);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (q_cmd.kind == CMD_LOAD))
                begin
                    fwe = 1'b1;
                    if (load_pos_reg == '0)
                    begin
                        cur_w_next       = lw;
                        cur_h_next       = lh;
                        cur_v_next       = cfg_regs.vmode;
                        total_next       = TW'(ltot);
                        frame_ready_next = 1'b0;
                    end
                    if (load_end)
                    begin
                        load_pos_next = '0;
                        cx_next       = '0;
                        cy_next       = '0;
                        cpos_next     = '0;
                        gk_next       = '0;
                        mask_ph_next  = 1'b0;
                        g_next        = '0;
                        black_next    = 1'b0;
                        etot_next     = '0;
                    end
                    else
                    begin
                        load_pos_next = load_pos_reg + TW'(1);
                    end
                end
                else if (pop)
                begin
                    if (!frame_ready_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_edge_next  = EDGE_OFF;
                        res_last_next  = 1'b0;
                        res_nr_next    = 1'b1;
                    end
                    else if (interior)
                    begin
                        rk_next = '0;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_edge_next  = EDGE_OFF;
                        res_last_next  = rlast;
                        res_nr_next    = 1'b0;
                        if (rlast)
                        begin
                            rpos_next = '0;
                            rx_next   = '0;
                            ry_next   = '0;
                        end
                        else
                        begin
                            rpos_next = rpos_reg + AW'(1);
                            if (rx_reg == cur_w_reg - DM_W'(1))
                            begin
                                rx_next = '0;
                                ry_next = ry_reg + DM_W'(1);
                            end
                            else
                            begin
                                rx_next = rx_reg + DM_W'(1);
                            end
                        end
                    end
                end
            end
            ST_C_ISSUE:
            begin
                a_vld_next = iss_vld;
                drain_next = '0;
                if (!mask_ph_reg)
                begin
                    if (gk_reg == GK_W'(GRAD_TAPS - 1))
                    begin
                        if (cur_v_reg)
                        begin
                            mask_ph_next = 1'b1;
                            mdx_next     = -RAD;
                            mdy_next     = -RAD;
                        end
                    end
                    else
                    begin
                        gk_next = gk_reg + GK_W'(1);
                    end
                end
                else
                begin
                    if (mdx_reg == RAD)
                    begin
                        mdx_next = -RAD;
                        if (mdy_reg != RAD)
                            mdy_next = mdy_reg + CO_W'(1);
                    end
                    else
                    begin
                        mdx_next = mdx_reg + CO_W'(1);
                    end
                end
            end
            ST_C_DRAIN:
            begin
                drain_next = drain_reg + DRAIN_W'(1);
            end
            ST_C_SQ:
            begin
                sq_next = (cur_v_reg && black_reg) ? '0 : gsq[EN_W-1:0];
            end
            ST_C_WR:
            begin
                ewe          = 1'b1;
                etot_next    = etot_reg + ETW'(sq_reg);
                gk_next      = '0;
                mask_ph_next = 1'b0;
                g_next       = '0;
                black_next   = 1'b0;
                cpos_next    = cpos_reg + AW'(1);
                if (c_last)
                begin
                    frame_ready_next = 1'b1;
                    rpos_next        = '0;
                    rx_next          = '0;
                    ry_next          = '0;
                end
                else if (cx_reg == cur_w_reg - DM_W'(1))
                begin
                    cx_next = '0;
                    cy_next = cy_reg + DM_W'(1);
                end
                else
                begin
                    cx_next = cx_reg + DM_W'(1);
                end
            end
            ST_R_ISSUE:
            begin
                cap_vld_next = 1'b1;
                rk_next      = rk_reg + RK_W'(1);
                case (nb_sel_t'(rk_reg))
                    NB_C:    eaddr_r = rpos_reg;
                    NB_L:    eaddr_r = rpos_reg - AW'(1);
                    NB_R:    eaddr_r = rpos_reg + AW'(1);
                    NB_U:    eaddr_r = rpos_reg - AW'(cur_w_reg);
                    NB_D:    eaddr_r = rpos_reg + AW'(cur_w_reg);
                    default: eaddr_r = rpos_reg;
                endcase
            end
            ST_R_WAIT:
            begin
            end
            ST_R_MUL:
            begin
                prod_next = PRW'(nb_reg[NB_C]) * PRW'(total_reg);
            end
            ST_R_DONE:
            begin
                res_valid_next = 1'b1;
                res_edge_next  = (over && (row_max || col_max)) ? EDGE_ON : EDGE_OFF;
                res_last_next  = rlast;
                res_nr_next    = 1'b0;
                if (rlast)
                begin
                    rpos_next = '0;
                    rx_next   = '0;
                    ry_next   = '0;
                end
                else
                begin
                    rpos_next = rpos_reg + AW'(1);
                    if (rx_reg == cur_w_reg - DM_W'(1))
                    begin
                        rx_next = '0;
                        ry_next = ry_reg + DM_W'(1);
                    end
                    else
                    begin
                        rx_next = rx_reg + DM_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            load_pos_reg    <= '0;
            frame_ready_reg <= 1'b0;
            etot_reg        <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            cpos_reg        <= '0;
            gk_reg          <= '0;
            mask_ph_reg     <= 1'b0;
            mdx_reg         <= '0;
            mdy_reg         <= '0;
            drain_reg       <= '0;
            a_vld_reg       <= 1'b0;
            b_vld_reg       <= 1'b0;
            rpos_reg        <= '0;
            rx_reg          <= '0;
            ry_reg          <= '0;
            rk_reg          <= '0;
            cap_vld_reg     <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            load_pos_reg    <= load_pos_next;
            frame_ready_reg <= frame_ready_next;
            etot_reg        <= etot_next;
            cx_reg          <= cx_next;
            cy_reg          <= cy_next;
            cpos_reg        <= cpos_next;
            gk_reg          <= gk_next;
            mask_ph_reg     <= mask_ph_next;
            mdx_reg         <= mdx_next;
            mdy_reg         <= mdy_next;
            drain_reg       <= drain_next;
            a_vld_reg       <= a_vld_next;
            b_vld_reg       <= b_vld_next;
            rpos_reg        <= rpos_next;
            rx_reg          <= rx_next;
            ry_reg          <= ry_next;
            rk_reg          <= rk_next;
            cap_vld_reg     <= cap_vld_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_w_reg    <= cur_w_next;
        cur_h_reg    <= cur_h_next;
        cur_v_reg    <= cur_v_next;
        total_reg    <= total_next;
        g_reg        <= g_next;
        black_reg    <= black_next;
        sq_reg       <= sq_next;
        a_addr_reg   <= a_addr_next;
        a_sign_reg   <= a_sign_next;
        a_ring_reg   <= a_ring_next;
        a_mask_reg   <= a_mask_next;
        b_sign_reg   <= b_sign_next;
        b_ring_reg   <= b_ring_next;
        b_mask_reg   <= b_mask_next;
        cap_idx_reg  <= cap_idx_next;
        nb_reg       <= nb_next;
        prod_reg     <= prod_next;
        res_edge_reg <= res_edge_next;
        res_last_reg <= res_last_next;
        res_nr_reg   <= res_nr_next;
    end

    always_ff @(posedge clk)
    begin
        if (fwe)
        begin
            fmem[faddr_w] <= q_cmd.pixel;
        end
        fdata_reg <= fmem[a_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ewe)
        begin
            emem[cpos_reg] <= sq_reg;
        end
        edata_reg <= emem[eaddr_r];
    end

    assign results.valid     = res_valid_reg;
    assign results.edge_res  = res_edge_reg;
    assign results.last      = res_last_reg;
    assign results.not_ready = res_nr_reg;

endmodule

// ===== src/prewitt_edge_nms_threshold.sv =====
`timescale 1ns / 1ps
// Prewitt edge detector with non-maximum suppression and a mean-based threshold.
// Items enter a two-entry command queue, so the input side keeps taking
// transactions while the engine is busy or a result waits, until the queue
// is full. A load item writes one pixel into the frame store. The last pixel of
// a frame starts the energy pass, during which no queued item is served: each
// pixel fetches six gradient taps, plus (2*MASK_RADIUS+1)^2 mask taps in
// vertical mode, through the single read port of the frame store, which fetches
// one neighbor per cycle. A read item on the frame border, or one given a
// not-ready reply, is answered from the idle state; one inside the frame first
// takes the five energy store reads and the threshold multiply.
`include "prewitt_edge_nms_threshold_defines.svh"
module prewitt_edge_nms_threshold import pent_pkg::*; #(
    parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = MAX_HEIGHT_DEF,
    parameter int THRESHOLD_FACTOR = THRESHOLD_FACTOR_DEF,
    parameter int MASK_RADIUS      = MASK_RADIUS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pent_item_if.sink   items,
    pent_res_if.source  results,
    pent_cfg_if.sink    cfg
);

    cfg_t      cfg_regs;
    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;
    cmd_t      push_cmd;
    cmd_t      head_cmd;

    pent_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_cmd    (push_cmd),
        .cfg_regs (cfg_regs)
    );

    pent_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    pent_back #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .THRESHOLD_FACTOR (THRESHOLD_FACTOR),
        .MASK_RADIUS      (MASK_RADIUS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs),
        .q_stat   (q_stat),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .results  (results)
    );

    `PENT_ASSERT_IMP(a_nr_no_edge, results.valid && results.not_ready, results.edge_res == EDGE_OFF && !results.last, "not-ready result carries data")
    `PENT_ASSERT_IMP(a_edge_code, results.valid, results.edge_res == EDGE_OFF || results.edge_res == EDGE_ON, "edge result is neither 0 nor 255")
    `PENT_ASSERT_NXT(a_nr_then_idle, results.valid && results.ready && results.not_ready, !(results.valid && results.last), "last result right after not-ready reply")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import pent_pkg::*;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_res;
        logic              last;
        logic              not_ready;
    } edge_result_t;

    class edge_scoreboard;
        logic [DIM_W-1:0] reg_w;
        logic [DIM_W-1:0] reg_h;
        logic             reg_v;
        int               cw;
        int               ch;
        bit               cv;
        byte unsigned     pix[];
        int unsigned      nrg[];
        longint           total;
        int               load_pos;
        int               read_pos;
        bit               frame_ok;
        bit               any_load;
        edge_result_t     exp_q[$];
        int               errors;
        int               checked;
        int               edges_seen;
        int               loads;
        int               reads;
        int               frames;
        int               vframes;

        function new();
            pix = new[MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
            nrg = new[MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
            reg_w = RESET_WIDTH;
            reg_h = RESET_HEIGHT;
            reg_v = 1'b0;
            cw = 640;
            ch = 480;
            cv = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [DIM_W-1:0] d);
            case (idx)
                REG_WIDTH:  reg_w = d;
                REG_HEIGHT: reg_h = d;
                REG_VMODE:  reg_v = d[0];
                default: ;
            endcase
        endfunction

        function int clamp_dim(int v, int m);
            return (v < MIN_DIM) ? MIN_DIM : ((v > m) ? m : v);
        endfunction

        function int mirror(int i, int n);
            if (i < 0) return 1;
            if (i >= n) return n - 2;
            return i;
        endfunction

        function int work_px(int y, int x);
            if (cv && (x == 0 || y == 0 || x == cw - 1 || y == ch - 1))
                return 0;
            return pix[y * cw + x];
        endfunction

        function void build_energy();
            int g;
            int yy;
            int xx;
            bit dark;
            longint e;
            total = 0;
            for (int y = 0; y < ch; y++) begin
                for (int x = 0; x < cw; x++) begin
                    g = 0;
                    for (int d = -1; d <= 1; d++) begin
                        if (cv) begin
                            yy = mirror(y + d, ch);
                            g += work_px(yy, mirror(x - 1, cw)) - work_px(yy, mirror(x + 1, cw));
                        end
                        else begin
                            xx = mirror(x + d, cw);
                            g += work_px(mirror(y - 1, ch), xx) - work_px(mirror(y + 1, ch), xx);
                        end
                    end
                    e = g * g;
                    if (cv) begin
                        dark = 0;
                        for (int dy = -MASK_RADIUS_DEF; dy <= MASK_RADIUS_DEF; dy++)
                            for (int dx = -MASK_RADIUS_DEF; dx <= MASK_RADIUS_DEF; dx++) begin
                                yy = y + dy;
                                xx = x + dx;
                                if (yy >= 0 && yy < ch && xx >= 0 && xx < cw)
                                    if (work_px(yy, xx) == 0) dark = 1;
                            end
                        if (dark) e = 0;
                    end
                    nrg[y * cw + x] = int'(e);
                    total += e;
                end
            end
        endfunction

        function void note_item(cmd_kind_t k, logic [PIX_W-1:0] p);
            edge_result_t r;
            int y;
            int x;
            longint e;
            longint n;
            bit row_max;
            bit col_max;
            if (k == CMD_LOAD) begin
                loads++;
                any_load = 1;
                if (load_pos == 0) begin
                    cw = clamp_dim(reg_w, MAX_WIDTH_DEF);
                    ch = clamp_dim(reg_h, MAX_HEIGHT_DEF);
                    cv = reg_v;
                    frame_ok = 0;
                end
                pix[load_pos] = p;
                load_pos++;
                if (load_pos >= cw * ch) begin
                    build_energy();
                    load_pos = 0;
                    read_pos = 0;
                    frame_ok = 1;
                    frames++;
                    if (cv) vframes++;
                end
                return;
            end
            reads++;
            r = '0;
            if (!frame_ok) begin
                r.not_ready = 1'b1;
                exp_q.push_back(r);
                return;
            end
            n = cw * ch;
            y = read_pos / cw;
            x = read_pos % cw;
            r.edge_res = EDGE_OFF;
            if (y > 0 && x > 0 && y < ch - 1 && x < cw - 1) begin
                e = nrg[read_pos];
                row_max = e > nrg[read_pos - 1] && e > nrg[read_pos + 1];
                col_max = e > nrg[read_pos - cw] && e > nrg[read_pos + cw];
                if (e * n > THRESHOLD_FACTOR_DEF * total && (row_max || col_max))
                    r.edge_res = EDGE_ON;
            end
            r.last = (read_pos == n - 1);
            read_pos = (read_pos + 1 >= n) ? 0 : read_pos + 1;
            exp_q.push_back(r);
        endfunction

        function void check_result(edge_result_t got);
            edge_result_t want;
            checked++;
            if (got.edge_res == EDGE_ON) edges_seen++;
            if (exp_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: edge_res=%0d last=%0b not_ready=%0b",
                             got.edge_res, got.last, got.not_ready);
                return;
            end
            want = exp_q.pop_front();
            if (got.edge_res !== want.edge_res || got.last !== want.last
                    || got.not_ready !== want.not_ready) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             checked, want.edge_res, want.last, want.not_ready,
                             got.edge_res, got.last, got.not_ready);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   rnd_items;

    pent_item_if items_if ();
    pent_res_if  res_if ();
    pent_cfg_if  cfg_if ();

    edge_scoreboard sb = new();

    prewitt_edge_nms_threshold u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if.sink),
        .results (res_if.source),
        .cfg     (cfg_if.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

    task automatic send_item(cmd_kind_t k, logic [PIX_W-1:0] p);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            items_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.kind  <= k;
        items_if.pixel <= p;
        @(posedge clk);
        while (!items_if.ready) @(posedge clk);
        sb.note_item(k, p);
    endtask

    task automatic write_cfg(cfg_reg_t idx, logic [DIM_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        sb.write_reg(idx, d);
    endtask

    // hold until every result is back and any energy pass has finished
    task automatic settle();
        items_if.valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge clk);
        if (sb.any_load)
            repeat (40 * sb.cw * sb.ch + 50) @(posedge clk);
        else
            repeat (20) @(posedge clk);
    endtask

    task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic v);
        settle();
        write_cfg(REG_WIDTH, w);
        write_cfg(REG_HEIGHT, h);
        write_cfg(REG_VMODE, {{(DIM_W-1){1'b0}}, v});
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(int style, int x, int w);
        case (style)
            0: return PIX_W'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            2: return PIX_W'(((x < w / 2) ? 20 : 200) + $urandom_range(0, 30));
            default: return PIX_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic read_n(int n);
        repeat (n) send_item(CMD_READ, '0);
    endtask

    initial
    begin
        int gap;
        int hold;
        bit held;
        gap = 0;
        hold = 0;
        held = 0;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                sb.check_result({res_if.edge_res, res_if.last, res_if.not_ready});
            if (!held && sb.checked >= 30)
            begin
                held = 1;
                hold = 400;
            end
            if (hold > 0)
                hold--;
            else if (gap > 0)
                gap--;
            else if (!calm && $urandom_range(0, 7) == 0)
                gap = $urandom_range(1, 3);
            res_if.ready <= (hold == 0 && gap == 0);
        end
    end

    initial
    begin
        int w;
        int h;
        int style;
        int n;
        rst_n = 1'b0;
        calm = 0;
        rnd_items = 0;
        items_if.valid <= 1'b0;
        items_if.kind  <= CMD_LOAD;
        items_if.pixel <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_WIDTH;
        cfg_if.data    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_n(2);
        set_frame(11'd3, 11'd3, 1'b0);
        for (int i = 0; i < 9; i++)
            send_item(CMD_LOAD, (i % 2) ? 8'd255 : 8'd0);
        read_n(11);

        set_frame(11'd6, 11'd5, 1'b1);
        send_item(CMD_LOAD, 8'd10);
        send_item(CMD_READ, '0);
        for (int i = 1; i < 30; i++)
            send_item(CMD_LOAD, (i == 14) ? 8'd0 : ((i % 6 < 3) ? 8'd30 : 8'd250));
        read_n(31);

        // out-of-range sizes clamp to a 3 x 3 frame
        set_frame(11'd1, 11'd0, 1'b0);
        for (int i = 0; i < 9; i++)
            send_item(CMD_LOAD, make_pixel(0, i % 3, 3));
        read_n(10);

        while (rnd_items < 1200)
        begin
            calm = rnd_items > 1000;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 8);
            h = $urandom_range(3, 8);
            set_frame(DIM_W'(w), DIM_W'(h), 1'($urandom_range(0, 1)));
            w = sb.clamp_dim(w, MAX_WIDTH_DEF);
            style = $urandom_range(0, 3);
            if (sb.load_pos != 0)
            begin
                w = sb.cw;
                h = sb.ch;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                n = $urandom_range(1, w * h - 1 - sb.load_pos);
                for (int i = 0; i < n; i++)
                    send_item(CMD_LOAD, make_pixel(style, i % w, w));
                read_n(2);
                rnd_items += n + 2;
            end
            else
            begin
                n = w * h - sb.load_pos;
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        send_item(CMD_READ, '0);
                        rnd_items++;
                    end
                    send_item(CMD_LOAD, make_pixel(style, (sb.load_pos) % w, w));
                end
                rnd_items += n;
                n = w * h + $urandom_range(0, w);
                read_n(n);
                rnd_items += n;
            end
        end

        settle();
        $display("covered %0d loads and %0d reads over %0d frames (%0d vertical)",
                 sb.loads, sb.reads, sb.frames, sb.vframes);
        $display("checked %0d results, %0d edge pixels, %0d mismatches",
                 sb.checked, sb.edges_seen, sb.errors);
        if (sb.errors == 0 && sb.exp_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/pent_pkg.sv
src/pent_if.sv
src/pent_front.sv
src/pent_fifo.sv
src/pent_back.sv
src/prewitt_edge_nms_threshold.sv
tb/sv/tb_top.sv
